// File: rtl/core/mpq_pkg.sv
// Shared constants, types and codes for the min priority queue block.
// No dependencies; compile first.
package mpq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int FILL_W   = 7;
  localparam int ACT_W    = 2;
  localparam int STAT_W   = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NOP  = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Controller to datapath
  typedef struct packed {
    logic accept;      // take the request transaction
    logic scan;        // walk the array looking for the minimum
    logic shift;       // walk the tail, moving each entry down one slot
    logic shift_init;  // start the tail walk just behind the minimum
    logic load_best;   // present the minimum as the result
    logic dec_count;   // the minimum leaves the queue
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic walk_done;
  } sts_t;

endpackage

// File: rtl/core/mpq_req_if.sv
// Request channel: valid/ready handshake with the queue operation payload.
// Depends on mpq_pkg.
interface mpq_req_if;
  logic                       valid;
  logic                       ready;
  logic [mpq_pkg::ACT_W-1:0]  action;
  logic [mpq_pkg::ID_W-1:0]   order_id;
  logic [mpq_pkg::PRIO_W-1:0] prio_in;

  modport source (output valid, action, order_id, prio_in, input ready);
  modport sink   (input valid, action, order_id, prio_in, output ready);
endinterface

// File: rtl/core/mpq_res_if.sv
// Result channel: valid/ready handshake with the queue result payload.
// Depends on mpq_pkg.
interface mpq_res_if;
  logic                       valid;
  logic                       ready;
  logic [mpq_pkg::ID_W-1:0]   out_id;
  logic [mpq_pkg::PRIO_W-1:0] out_prio;
  logic [mpq_pkg::STAT_W-1:0] status;
  logic [mpq_pkg::FILL_W-1:0] fill_count;

  modport source (output valid, out_id, out_prio, status, fill_count, input ready);
  modport sink   (input valid, out_id, out_prio, status, fill_count, output ready);
endinterface

// File: rtl/core/mpq_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module mpq_ram #(
  parameter int Width = 24,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mpq_datapath.sv
// Queue datapath: entry RAM, count, walk pointer, minimum tracker, result registers.
// Depends on mpq_pkg and mpq_ram.
module mpq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mpq_pkg::cmd_t                cmd_i,
  input  logic [mpq_pkg::ACT_W-1:0]    action_i,
  input  logic [mpq_pkg::ID_W-1:0]     order_id_i,
  input  logic [mpq_pkg::PRIO_W-1:0]   prio_in_i,
  output mpq_pkg::sts_t                sts_o,
  output logic [mpq_pkg::ID_W-1:0]     out_id_o,
  output logic [mpq_pkg::PRIO_W-1:0]   out_prio_o,
  output logic [mpq_pkg::STAT_W-1:0]   status_o,
  output logic [mpq_pkg::FILL_W-1:0]   fill_count_o
);

  logic [mpq_pkg::CNT_W-1:0]  count_q, count_d;
  logic [mpq_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic                       pend_q, pend_d;
  logic [mpq_pkg::IDX_W-1:0]  addr_q, addr_d;
  mpq_pkg::entry_t            best_q, best_d;
  logic [mpq_pkg::IDX_W-1:0]  best_idx_q, best_idx_d;
  logic [mpq_pkg::ID_W-1:0]   out_id_q, out_id_d;
  logic [mpq_pkg::PRIO_W-1:0] out_prio_q, out_prio_d;
  logic [mpq_pkg::STAT_W-1:0] status_q, status_d;
  logic [mpq_pkg::FILL_W-1:0] fill_q, fill_d;

  logic                        ram_we;
  logic [mpq_pkg::IDX_W-1:0]   ram_waddr;
  mpq_pkg::entry_t             ram_wdata;
  mpq_pkg::entry_t             ram_rdata;
  logic [mpq_pkg::ENTRY_W-1:0] ram_rdata_raw;
  logic [mpq_pkg::IDX_W-1:0]   rd_idx;
  logic                        walk_more;
  logic                        full;
  logic [mpq_pkg::CNT_W-1:0]   count_inc;
  logic [mpq_pkg::CNT_W-1:0]   count_dec;

  assign rd_idx    = idx_q[mpq_pkg::IDX_W-1:0];
  assign walk_more = (idx_q < count_q);
  assign full      = (count_q == mpq_pkg::CNT_W'(mpq_pkg::CAPACITY));
  assign count_inc = count_q + mpq_pkg::CNT_W'(1);
  assign count_dec = count_q - mpq_pkg::CNT_W'(1);
  assign ram_rdata = mpq_pkg::entry_t'(ram_rdata_raw);

  always_comb begin
    count_d    = count_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    addr_d     = addr_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    out_id_d   = out_id_q;
    out_prio_d = out_prio_q;
    status_d   = status_q;
    fill_d     = fill_q;
    ram_we     = 1'b0;
    ram_waddr  = count_q[mpq_pkg::IDX_W-1:0];
    ram_wdata  = '{id: order_id_i, prio: prio_in_i};

    if (cmd_i.accept) begin
      unique case (mpq_pkg::action_e'(action_i))
        mpq_pkg::ACT_ENQ: begin
          out_id_d   = '0;
          out_prio_d = '0;
          if (full) begin
            status_d = mpq_pkg::ST_FULL;
            fill_d   = mpq_pkg::FILL_W'(count_q);
          end else begin
            ram_we   = 1'b1;
            count_d  = count_inc;
            status_d = mpq_pkg::ST_OK;
            fill_d   = mpq_pkg::FILL_W'(count_inc);
          end
        end
        mpq_pkg::ACT_DEQ, mpq_pkg::ACT_PEEK: begin
          out_id_d   = '0;
          out_prio_d = '0;
          status_d   = mpq_pkg::ST_EMPTY;
          fill_d     = mpq_pkg::FILL_W'(count_q);
          idx_d      = '0;
          pend_d     = 1'b0;
        end
        mpq_pkg::ACT_NOP: begin
          out_id_d   = '0;
          out_prio_d = '0;
          status_d   = mpq_pkg::ST_OK;
          fill_d     = mpq_pkg::FILL_W'(count_q);
        end
        default: ;
      endcase
    end

    // one RAM read issued per cycle while the pointer is below the count
    if (cmd_i.scan || cmd_i.shift) begin
      pend_d = walk_more;
      if (walk_more) begin
        idx_d  = idx_q + mpq_pkg::CNT_W'(1);
        addr_d = rd_idx;
      end
    end

    // strict compare keeps the earliest of equal priorities
    if (cmd_i.scan && pend_q) begin
      if ((addr_q == '0) || (ram_rdata.prio < best_q.prio)) begin
        best_d     = ram_rdata;
        best_idx_d = addr_q;
      end
    end

    if (cmd_i.shift && pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = addr_q - mpq_pkg::IDX_W'(1);
      ram_wdata = ram_rdata;
    end

    if (cmd_i.shift_init) begin
      idx_d  = mpq_pkg::CNT_W'(best_idx_q) + mpq_pkg::CNT_W'(1);
      pend_d = 1'b0;
    end

    if (cmd_i.load_best) begin
      out_id_d   = best_q.id;
      out_prio_d = best_q.prio;
      status_d   = mpq_pkg::ST_OK;
      if (cmd_i.dec_count) begin
        count_d = count_dec;
        fill_d  = mpq_pkg::FILL_W'(count_dec);
      end else begin
        fill_d  = mpq_pkg::FILL_W'(count_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_id_q   <= out_id_d;
    out_prio_q <= out_prio_d;
    status_q   <= status_d;
    fill_q     <= fill_d;
  end

  mpq_ram #(
    .Width (mpq_pkg::ENTRY_W),
    .Depth (mpq_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata_raw)
  );

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.walk_done  = !walk_more && !pend_q;

  assign out_id_o     = out_id_q;
  assign out_prio_o   = out_prio_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

endmodule

// File: rtl/core/mpq_ctrl.sv
// Queue controller: sequences scan and shift walks, owns the handshake flags.
// Depends on mpq_pkg.
module mpq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  input  logic [mpq_pkg::ACT_W-1:0] req_action_i,
  input  logic                      res_ready_i,
  input  mpq_pkg::sts_t             sts_i,
  output logic                      req_ready_o,
  output logic                      res_valid_o,
  output mpq_pkg::cmd_t             cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   is_deq_q, is_deq_d;
  logic   accept;
  logic   needs_scan;

  assign req_ready_o = (state_q == S_IDLE) && (!out_valid_q || res_ready_i);
  assign accept      = req_valid_i && req_ready_o;
  assign needs_scan  = !sts_i.count_zero &&
                       ((mpq_pkg::action_e'(req_action_i) == mpq_pkg::ACT_DEQ) ||
                        (mpq_pkg::action_e'(req_action_i) == mpq_pkg::ACT_PEEK));

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    is_deq_d    = is_deq_q;
    cmd_o       = '0;
    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (needs_scan) begin
            state_d  = S_SCAN;
            is_deq_d = (mpq_pkg::action_e'(req_action_i) == mpq_pkg::ACT_DEQ);
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.walk_done) begin
          if (is_deq_q) begin
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT;
          end else begin
            cmd_o.load_best = 1'b1;
            out_valid_d     = 1'b1;
            state_d         = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.walk_done) begin
          cmd_o.load_best = 1'b1;
          cmd_o.dec_count = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      is_deq_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      is_deq_q    <= is_deq_d;
    end
  end

  assign res_valid_o = out_valid_q;

endmodule

// File: rtl/core/min_priority_queue_array.sv
// Min priority queue over an unsorted array kept in arrival order.
// Channels: req_i (sink) takes one operation per transaction: enqueue, dequeue
// or peek, plus order_id/prio_in for an enqueue. res_o (source) returns exactly
// one result transaction per request: id and priority of the minimum (zero if
// none), a status code and the fill count after the operation.
// Operation flow, with n stored entries and the minimum at slot m:
//   enqueue / unused code / empty dequeue or peek: result in the cycle after accept.
//   peek: a RAM scan of the n entries, one read per cycle.
//   dequeue: the same scan, then a walk over the entries behind slot m that closes
//   the gap; the single read port of the entry RAM sets both walks.
// One operation is in flight at a time; the next request is taken in the cycle
// the result is handed over, or earlier if the result register is empty.
// Reset (rst_ni low, asynchronous) empties the queue at once; the entry RAM
// itself is not cleared, as only slots below the count are ever read.
// If the receiver stalls, the result is held in its register and req_i.ready
// stays low until the result transaction completes.
// Depends on mpq_pkg, mpq_req_if, mpq_res_if, mpq_ctrl, mpq_datapath, mpq_ram.
module min_priority_queue_array (
  input logic       clk_i,
  input logic       rst_ni,
  mpq_req_if.sink   req_i,
  mpq_res_if.source res_o
);

  mpq_pkg::cmd_t cmd;
  mpq_pkg::sts_t sts;

  // sequencing: idle / scan for minimum / shift tail down
  mpq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .res_ready_i  (res_o.ready),
    .sts_i        (sts),
    .req_ready_o  (req_i.ready),
    .res_valid_o  (res_o.valid),
    .cmd_o        (cmd)
  );

  // storage, pointers and the result register
  mpq_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .action_i     (req_i.action),
    .order_id_i   (req_i.order_id),
    .prio_in_i    (req_i.prio_in),
    .sts_o        (sts),
    .out_id_o     (res_o.out_id),
    .out_prio_o   (res_o.out_prio),
    .status_o     (res_o.status),
    .fill_count_o (res_o.fill_count)
  );

endmodule

// File: rtl/core/mpq_checker.sv
// Port-level checks for the min priority queue, bound to the top level.
// Depends on mpq_pkg and min_priority_queue_array.
module mpq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [mpq_pkg::ID_W-1:0]   out_id_i,
  input logic [mpq_pkg::PRIO_W-1:0] out_prio_i,
  input logic [mpq_pkg::STAT_W-1:0] status_i,
  input logic [mpq_pkg::FILL_W-1:0] fill_count_i
);

  // a stalled result must stay offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // after a request transaction the block either shows a result or is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> res_valid_i || !req_ready_i)
    else $error("request taken without result or busy");

  // empty result carries zero payload and zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == mpq_pkg::ST_EMPTY) |->
      (out_id_i == '0) && (out_prio_i == '0) && (fill_count_i == '0))
    else $error("empty result with non-zero fields");

  // a dropped enqueue reports the queue at capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i == mpq_pkg::ST_FULL) |->
      (fill_count_i == mpq_pkg::FILL_W'(mpq_pkg::CAPACITY)) && (out_id_i == '0))
    else $error("full status with wrong count or payload");

endmodule

bind min_priority_queue_array mpq_checker u_mpq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .out_id_i     (res_o.out_id),
  .out_prio_i   (res_o.out_prio),
  .status_i     (res_o.status),
  .fill_count_i (res_o.fill_count)
);

// File: test/min_priority_queue_array_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for min_priority_queue_array: a shadow queue predicts every result.
// Depends on mpq_pkg, mpq_req_if, mpq_res_if and the block's RTL.
module min_priority_queue_array_tb;
  import mpq_pkg::*;

  // Slowest correct item: a dequeue on a full queue, which scans all CAPACITY entries
  // and then closes the gap. On top of that come the longest sender gap and a receiver
  // stall. The limit is several times that sum.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet time after the last result, so that a stray result can still show up.
  localparam int SETTLE_CYCLES  = 2 * CAPACITY + 8;
  localparam int RANDOM_ITEMS   = 700;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    status_e           status;
    logic [FILL_W-1:0] fill;
  } queue_result_t;

  typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_CHOPPY} rx_mode_e;

  logic clk;
  logic rst_n;

  mpq_req_if req_if ();
  mpq_res_if res_if ();

  min_priority_queue_array u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Shadow copy of the queue contents, kept in arrival order
  logic [ID_W-1:0]   shadow_ids   [CAPACITY];
  logic [PRIO_W-1:0] shadow_prios [CAPACITY];
  int                shadow_count;

  queue_result_t pending_results [$];

  int errors;
  int results_checked;
  int items_sent;
  int burst_left;
  bit gaps_on;

  // Run statistics for the closing summary
  int n_enq, n_dropped, n_deq, n_peek, n_empty, n_nop, max_fill;

  // Clock: 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one operation to the shadow queue and return the result it must produce.
  // The minimum is the earliest entry with the lowest priority; a dequeue closes
  // the gap behind it so that arrival order is preserved.
  function automatic queue_result_t predict_queue_op(action_e act, logic [ID_W-1:0] id,
                                                     logic [PRIO_W-1:0] prio);
    queue_result_t r;
    int best;
    r.id     = '0;
    r.prio   = '0;
    r.status = ST_OK;
    case (act)
      ACT_ENQ: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_ids[shadow_count]   = id;
          shadow_prios[shadow_count] = prio;
          shadow_count++;
        end
      end
      ACT_DEQ, ACT_PEEK: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_prios[i] < shadow_prios[best]) best = i;
          end
          r.id   = shadow_ids[best];
          r.prio = shadow_prios[best];
          if (act == ACT_DEQ) begin
            for (int i = best; i + 1 < shadow_count; i++) begin
              shadow_ids[i]   = shadow_ids[i + 1];
              shadow_prios[i] = shadow_prios[i + 1];
            end
            shadow_count--;
          end
        end
      end
      default: ; // unused code: nothing changes
    endcase
    r.fill = FILL_W'(shadow_count);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Send one request transaction. The sender works in bursts: when a burst runs out,
  // valid drops for a random gap. Valid otherwise stays high from one transaction to
  // the next, so it is never lowered and raised within one time step.
  // Called at a rising edge; returns at the edge where the transaction was accepted.
  task automatic send_op(input action_e act, input logic [ID_W-1:0] id,
                         input logic [PRIO_W-1:0] prio);
    int gap;
    queue_result_t r;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.order_id <= id;
    req_if.prio_in  <= prio;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    r = predict_queue_op(act, id, prio);
    pending_results.push_back(r);
    case (act)
      ACT_ENQ:  begin n_enq++;  if (r.status == ST_FULL) n_dropped++; end
      ACT_DEQ:  n_deq++;
      ACT_PEEK: n_peek++;
      default:  n_nop++;
    endcase
    if (r.status == ST_EMPTY) n_empty++;
    if (act != ACT_NOP) items_sent++;
    if (shadow_count > max_fill) max_fill = shadow_count;
  endtask

  // Hold the sender off until every outstanding result has been handed over
  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Empty-queue behaviour, field extremes, ties and the minimum at head, middle and tail
  task automatic test_directed_edges();
    gaps_on = 1'b0;
    send_op(ACT_DEQ,  16'h0000, 8'h00);  // empty dequeue
    send_op(ACT_PEEK, 16'hFFFF, 8'hFF);  // empty peek, payload ignored
    send_op(ACT_NOP,  16'hFFFF, 8'hFF);  // unused code on an empty queue
    send_op(ACT_ENQ,  16'hFFFF, 8'hFF);
    send_op(ACT_ENQ,  16'h0000, 8'h00);
    send_op(ACT_ENQ,  16'h1234, 8'h00);  // ties with the entry before it
    send_op(ACT_NOP,  16'h0000, 8'h00);  // unused code with entries stored
    send_op(ACT_PEEK, 16'h0000, 8'h00);
    send_op(ACT_DEQ,  16'h0000, 8'h00);  // earliest of the tie
    send_op(ACT_DEQ,  16'h0000, 8'h00);  // later of the tie
    send_op(ACT_DEQ,  16'h0000, 8'h00);  // last entry
    send_op(ACT_DEQ,  16'h0000, 8'h00);  // empty again
    gaps_on = 1'b1;
    send_op(ACT_ENQ,  16'hAAAA, 8'd5);
    send_op(ACT_ENQ,  16'h5555, 8'd3);
    send_op(ACT_ENQ,  16'h00C3, 8'd9);
    send_op(ACT_DEQ,  16'h0000, 8'h00);  // minimum in the middle
    send_op(ACT_ENQ,  16'h7E81, 8'd1);
    send_op(ACT_PEEK, 16'h0000, 8'h00);  // minimum at the tail
    send_op(ACT_DEQ,  16'h0000, 8'h00);
    send_op(ACT_DEQ,  16'h0000, 8'h00);  // minimum at the head
    send_op(ACT_DEQ,  16'h0000, 8'h00);
    send_op(ACT_PEEK, 16'h0000, 8'h00);
  endtask

  // Fill to capacity, push against the limit, then drain past empty
  task automatic test_fill_to_capacity();
    gaps_on = 1'b1;
    for (int i = 0; i < CAPACITY; i++) begin
      send_op(ACT_ENQ, ID_W'($urandom), PRIO_W'($urandom));
    end
    send_op(ACT_ENQ,  ID_W'($urandom), 8'h00);  // dropped even at the best priority
    send_op(ACT_ENQ,  ID_W'($urandom), 8'hFF);
    send_op(ACT_PEEK, 16'h0000, 8'h00);
    send_op(ACT_NOP,  16'h0000, 8'h00);
    for (int i = 0; i <= CAPACITY; i++) begin
      send_op(ACT_DEQ, ID_W'($urandom), PRIO_W'($urandom));
    end
  endtask

  // Random operations in segments. Each segment leans towards filling, draining or
  // holding the level, draws priorities from a wide, narrow (many ties) or extreme
  // range, and may run without sender gaps. Some segments end in a full pause.
  task automatic test_random_mix();
    int seg_left;
    int enq_pct;
    int prio_mode;
    int pick;
    action_e act;
    logic [PRIO_W-1:0] prio;
    seg_left  = 0;
    enq_pct   = 50;
    prio_mode = 0;
    while (items_sent < RANDOM_ITEMS + 140) begin
      if (seg_left == 0) begin
        if ($urandom_range(0, 5) == 0) wait_for_results();
        seg_left  = $urandom_range(20, 90);
        case ($urandom_range(0, 2))
          0:       enq_pct = 70;
          1:       enq_pct = 25;
          default: enq_pct = 45;
        endcase
        prio_mode = $urandom_range(0, 2);
        gaps_on   = ($urandom_range(0, 3) != 0);
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      if (pick < 3)                act = ACT_NOP;
      else if (pick < 3 + enq_pct) act = ACT_ENQ;
      else if (pick < 18 + enq_pct) act = ACT_PEEK;
      else                         act = ACT_DEQ;
      case (prio_mode)
        0:       prio = PRIO_W'($urandom);
        1:       prio = PRIO_W'($urandom_range(0, 3));
        default: prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      send_op(act, ID_W'($urandom), prio);
    end
  endtask

  // Receiver: ready follows a randomly chosen mode, drawn anew when its run ends
  initial begin : receiver
    rx_mode_e mode;
    int mode_left;
    int phase;
    res_if.ready = 1'b0;
    mode         = RX_STEADY;
    mode_left    = 0;
    phase        = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      phase++;
      case (mode)
        RX_STEADY: res_if.ready <= 1'b1;
        RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: res_if.ready <= ($urandom_range(0, 4) == 0);
        default:   res_if.ready <= ((phase % 11) < 3);
      endcase
    end
  end

  // Result checker: every result transaction against the oldest expectation
  initial begin : result_checker
    queue_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, id 0x%0h prio 0x%0h status %0d fill %0d",
                   $time, res_if.out_id, res_if.out_prio, res_if.status, res_if.fill_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          compare_field("out_id",     want.id,              res_if.out_id);
          compare_field("out_prio",   16'(want.prio),       16'(res_if.out_prio));
          compare_field("status",     16'(want.status),     16'(res_if.status));
          compare_field("fill_count", 16'(want.fill),       16'(res_if.fill_count));
          results_checked++;
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without any transaction ends the run
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_results.size());
    $display("FAIL");
    $finish;
  end

  initial begin : main_sequence
    rst_n           = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = ACT_NOP;
    req_if.order_id = '0;
    req_if.prio_in  = '0;
    errors          = 0;
    results_checked = 0;
    items_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b0;
    shadow_count    = 0;
    n_enq = 0; n_dropped = 0; n_deq = 0; n_peek = 0; n_empty = 0; n_nop = 0; max_fill = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    wait_for_results();
    test_fill_to_capacity();
    wait_for_results();
    test_random_mix();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      errors++;
    end
    $display("Covered %0d enqueues (%0d refused when full), %0d dequeues, %0d peeks,",
             n_enq, n_dropped, n_deq, n_peek);
    $display("%0d on an empty queue, %0d unused codes, peak fill %0d; %0d results checked",
             n_empty, n_nop, max_fill, results_checked);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
